/* sv/deflate_token_huffman_encoder_core_assert.svh */
// Assertion macros used by the encoder core.
// Each macro checks a property at the rising edge of clk_i while rst_ni is high.
`ifndef DEFLATE_TOKEN_HUFFMAN_ENCODER_CORE_ASSERT_SVH
`define DEFLATE_TOKEN_HUFFMAN_ENCODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DTHE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");
`define DTHE_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define DTHE_ASSERT(label, prop)
`define DTHE_ASSERT_NEVER(label, expr)
`endif
`endif

/* sv/dthe_pkg.sv */
package dthe_pkg;

  // Token operations.
  typedef enum logic [2:0] {
    OP_LOAD_LL   = 3'd0,
    OP_LOAD_DIST = 3'd1,
    OP_LITERAL   = 3'd2,
    OP_MATCH     = 3'd3,
    OP_END_BLOCK = 3'd4
  } op_e;

  // Configuration register indexes.
  localparam logic CFG_FIXED_CODES = 1'b0;
  localparam logic CFG_SUPPRESS_EOB = 1'b1;

  // Table geometry.
  localparam int unsigned LL_DEPTH   = 288;
  localparam int unsigned DIST_DEPTH = 32;
  localparam int unsigned ENTRY_W    = 20;

  // Special literal/length symbols.
  localparam logic [8:0] SYM_EOB     = 9'd256;
  localparam logic [8:0] SYM_LEN_258 = 9'd285;

  // One input request.
  typedef struct packed {
    logic [2:0]  op;
    logic [8:0]  symbol;
    logic [8:0]  match_length;
    logic [15:0] match_distance;
    logic [15:0] entry_code;
    logic [3:0]  entry_length;
  } token_t;

  // One output request.
  typedef struct packed {
    logic [47:0] code_bits;
    logic [5:0]  bit_count;
  } code_t;

  // One table entry: code length over the bit-reversed code.
  typedef struct packed {
    logic [3:0]  len;
    logic [15:0] code;
  } entry_t;

  // Decoded token, carried from the accept stage into the lookup stage.
  typedef struct packed {
    logic        is_match;
    logic        lit_oob;
    logic [8:0]  ll_sym;
    logic [2:0]  len_ne;
    logic [4:0]  len_ex;
    logic [4:0]  dist_sym;
    logic [3:0]  dist_ne;
    logic [12:0] dist_ex;
  } decode_t;

  // Length part and distance part, each with its own bit count.
  typedef struct packed {
    logic [19:0] ll_bits;
    logic [4:0]  ll_count;
    logic [27:0] dist_bits;
    logic [4:0]  dist_count;
  } parts_t;

  // Reverse the order of nine bits.
  function automatic logic [8:0] rev9(input logic [8:0] v);
    logic [8:0] r;
    for (int i = 0; i < 9; i++) begin
      r[i] = v[8 - i];
    end
    return r;
  endfunction

  // Built-in fixed literal/length code for a symbol below 288.
  function automatic entry_t fixed_ll_entry(input logic [8:0] sym);
    logic [8:0] val;
    logic [3:0] len;
    logic [8:0] rev;
    entry_t     e;
    if (sym < 9'd144) begin
      val = 9'h030 + sym;
      len = 4'd8;
    end else if (sym < 9'd256) begin
      val = 9'h190 + sym - 9'd144;
      len = 4'd9;
    end else if (sym < 9'd280) begin
      val = sym - 9'd256;
      len = 4'd7;
    end else begin
      val = 9'h0C0 + sym - 9'd280;
      len = 4'd8;
    end
    rev = rev9(val) >> (4'd9 - len);
    e.len  = len;
    e.code = {7'd0, rev};
    return e;
  endfunction

  // Built-in fixed distance code: five bits, reversed.
  function automatic entry_t fixed_dist_entry(input logic [4:0] sym);
    entry_t e;
    e.len = 4'd5;
    e.code = '0;
    for (int i = 0; i < 5; i++) begin
      e.code[i] = sym[4 - i];
    end
    return e;
  endfunction

  // Code bits of an entry with everything at or above its length cleared.
  function automatic logic [15:0] masked_code(input entry_t e);
    logic [15:0] m;
    for (int i = 0; i < 16; i++) begin
      m[i] = e.code[i] & (5'(i) < {1'b0, e.len});
    end
    return m;
  endfunction

endpackage

/* sv/dthe_ram.sv */
module dthe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port; read data holds without a read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/dthe_decode.sv */
module dthe_decode (
  input  dthe_pkg::token_t  tok_i,
  input  logic              suppress_eob_i,
  output logic              emit_o,
  output dthe_pkg::decode_t dec_o
);

  logic [8:0]  mlen;
  logic [8:0]  lval;
  logic [7:0]  l8;
  logic [2:0]  lm;
  logic [2:0]  ne;
  logic [4:0]  ex;
  logic [8:0]  len_sym;
  logic        dist_escape;
  logic [14:0] dval;
  logic [3:0]  dm;
  logic [3:0]  dne;
  logic [12:0] dex;
  logic [4:0]  dsym;

  // Length symbol, extra bit count and extra bits.
  always_comb begin
    if (tok_i.match_length < 9'd3) begin
      mlen = 9'd3;
    end else if (tok_i.match_length > 9'd259) begin
      mlen = 9'd259;
    end else begin
      mlen = tok_i.match_length;
    end
    lval = mlen - 9'd3;
    // Length 259 takes the long form of symbol 284 with all extra bits set.
    l8 = (lval == 9'h100) ? 8'hFF : lval[7:0];
    lm = '0;
    for (int i = 1; i < 8; i++) begin
      if (l8[i]) begin
        lm = 3'(i);
      end
    end
    ne = (lm < 3'd2) ? 3'd0 : lm - 3'd2;
    ex = 5'(l8 & ((8'd1 << ne) - 8'd1));
    if (lval == 9'h0FF) begin
      // Length 258 has a symbol of its own.
      len_sym = dthe_pkg::SYM_LEN_258;
      ne      = '0;
      ex      = '0;
    end else begin
      len_sym = 9'(l8 >> ne) + 9'({ne, 2'b00}) + 9'd257;
    end
  end

  // Distance symbol, extra bit count and extra bits.
  always_comb begin
    dist_escape = (tok_i.match_distance == 16'd0) || (tok_i.match_distance > 16'd32768);
    dval = 15'(tok_i.match_distance - 16'd1);
    dm = '0;
    for (int i = 1; i < 15; i++) begin
      if (dval[i]) begin
        dm = 4'(i);
      end
    end
    dne = (dm < 4'd1) ? 4'd0 : dm - 4'd1;
    dex = 13'(dval & ((15'd1 << dne) - 15'd1));
    dsym = 5'((dval >> dne) + 15'({dne, 1'b0}));
    // Escaped distances map straight onto a symbol with no extra bits.
    if (dist_escape) begin
      dsym = tok_i.match_distance[4:0];
      dne  = '0;
      dex  = '0;
    end
  end

  // Per-operation selection of the table address and result flag.
  always_comb begin
    emit_o = 1'b0;
    dec_o  = '0;
    case (tok_i.op)
      dthe_pkg::OP_LITERAL: begin
        emit_o        = 1'b1;
        dec_o.lit_oob = (tok_i.symbol >= 9'(dthe_pkg::LL_DEPTH));
        dec_o.ll_sym  = dec_o.lit_oob ? 9'd0 : tok_i.symbol;
      end
      dthe_pkg::OP_MATCH: begin
        emit_o         = 1'b1;
        dec_o.is_match = 1'b1;
        dec_o.ll_sym   = len_sym;
        dec_o.len_ne   = ne;
        dec_o.len_ex   = ex;
        dec_o.dist_sym = dsym;
        dec_o.dist_ne  = dne;
        dec_o.dist_ex  = dex;
      end
      dthe_pkg::OP_END_BLOCK: begin
        emit_o       = !suppress_eob_i;
        dec_o.ll_sym = dthe_pkg::SYM_EOB;
      end
      default: begin
        emit_o = 1'b0;
      end
    endcase
  end

endmodule

/* sv/dthe_entry_fmt.sv */
module dthe_entry_fmt (
  input  dthe_pkg::decode_t dec_i,
  input  logic              fixed_codes_i,
  input  dthe_pkg::entry_t  ll_entry_i,
  input  dthe_pkg::entry_t  dist_entry_i,
  output dthe_pkg::parts_t  parts_o
);

  dthe_pkg::entry_t ll_e;
  dthe_pkg::entry_t dist_e;

  // Pick the fixed codes or the loaded table entries.
  always_comb begin
    ll_e   = fixed_codes_i ? dthe_pkg::fixed_ll_entry(dec_i.ll_sym) : ll_entry_i;
    dist_e = fixed_codes_i ? dthe_pkg::fixed_dist_entry(dec_i.dist_sym) : dist_entry_i;
  end

  // Each code is followed by its extra bits.
  always_comb begin
    parts_o = '0;
    if (!dec_i.lit_oob) begin
      parts_o.ll_bits  = 20'(dthe_pkg::masked_code(ll_e)) | (20'(dec_i.len_ex) << ll_e.len);
      parts_o.ll_count = 5'(ll_e.len) + 5'(dec_i.len_ne);
    end
    if (dec_i.is_match) begin
      parts_o.dist_bits  = 28'(dthe_pkg::masked_code(dist_e))
                           | (28'(dec_i.dist_ex) << dist_e.len);
      parts_o.dist_count = 5'(dist_e.len) + 5'(dec_i.dist_ne);
    end
  end

endmodule

/* sv/deflate_token_huffman_encoder_core.sv */
// DEFLATE token to Huffman code encoder.
// Input channel: in_valid_i / in_stall_o carry one token request (in_token_i).
// Table loads (literal/length and distance) are written at acceptance and give
// no result; literals, matches and end of block give one code request each
// on out_valid_o / out_stall_i (out_code_o), LSB first, length part then
// distance part. A suppressed end of block and unknown operations give none.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 selects the fixed codes, 1 suppresses the end-of-block code).
// The three register stages are decode and table read, entry select and
// word assembly; out_valid_o is the valid bit of the last stage.
// Throughput: one token per cycle while no stall holds the pipeline; the
// literal/length table is read once per coded token, the distance table per match.
// Reset clears the configuration and all valid bits; the tables are not
// cleared and must be loaded before use unless fixed codes are selected.
// When the receiver stalls, the output register holds its request and each
// stage keeps its item; empty stages keep filling, and in_stall_o rises only
// when every stage is occupied.
module deflate_token_huffman_encoder_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic             cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  dthe_pkg::token_t in_token_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dthe_pkg::code_t  out_code_o
);

  logic              fixed_codes_q;
  logic              suppress_eob_q;
  logic              rdy_out;
  logic              rdy2;
  logic              rdy1;
  logic              accept;
  logic              emit;
  dthe_pkg::decode_t dec;
  logic              s1_valid_q;
  dthe_pkg::decode_t s1_q;
  logic              s2_valid_q;
  dthe_pkg::parts_t  s2_q;
  dthe_pkg::parts_t  parts;
  logic              out_valid_q;
  dthe_pkg::code_t   out_q;
  dthe_pkg::code_t   out_d;
  logic              ll_we;
  logic              dist_we;
  logic              ll_re;
  logic              dist_re;
  logic [dthe_pkg::ENTRY_W-1:0] ll_rdata;
  logic [dthe_pkg::ENTRY_W-1:0] dist_rdata;
  logic [dthe_pkg::ENTRY_W-1:0] wr_entry;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_codes_q  <= 1'b0;
      suppress_eob_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == dthe_pkg::CFG_FIXED_CODES) begin
        fixed_codes_q <= cfg_data_i;
      end
      if (cfg_idx_i == dthe_pkg::CFG_SUPPRESS_EOB) begin
        suppress_eob_q <= cfg_data_i;
      end
    end
  end

  // A stage moves when it is empty or the stage after it moves.
  assign rdy_out    = !out_valid_q || !out_stall_i;
  assign rdy2       = !s2_valid_q || rdy_out;
  assign rdy1       = !s1_valid_q || rdy2;
  assign in_stall_o = !rdy1;
  assign accept     = in_valid_i && rdy1;

  dthe_decode u_decode (
    .tok_i          (in_token_i),
    .suppress_eob_i (suppress_eob_q),
    .emit_o         (emit),
    .dec_o          (dec)
  );

  // Table writes for load requests, table reads for coding requests.
  assign wr_entry = {in_token_i.entry_length, in_token_i.entry_code};
  assign ll_we    = accept && (in_token_i.op == dthe_pkg::OP_LOAD_LL)
                    && (in_token_i.symbol < 9'(dthe_pkg::LL_DEPTH));
  assign dist_we  = accept && (in_token_i.op == dthe_pkg::OP_LOAD_DIST)
                    && (in_token_i.symbol < 9'(dthe_pkg::DIST_DEPTH));
  assign ll_re    = accept && emit;
  assign dist_re  = accept && emit && dec.is_match;

  dthe_ram #(
    .Width (dthe_pkg::ENTRY_W),
    .Depth (dthe_pkg::LL_DEPTH)
  ) u_ll_ram (
    .clk_i   (clk_i),
    .we_i    (ll_we),
    .waddr_i (in_token_i.symbol),
    .wdata_i (wr_entry),
    .re_i    (ll_re),
    .raddr_i (dec.ll_sym),
    .rdata_o (ll_rdata)
  );

  dthe_ram #(
    .Width (dthe_pkg::ENTRY_W),
    .Depth (dthe_pkg::DIST_DEPTH)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (in_token_i.symbol[4:0]),
    .wdata_i (wr_entry),
    .re_i    (dist_re),
    .raddr_i (dec.dist_sym),
    .rdata_o (dist_rdata)
  );

  // Stage one: decoded token, table data arrives alongside.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rdy1) begin
      s1_valid_q <= accept && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      s1_q <= dec;
    end
  end

  dthe_entry_fmt u_entry_fmt (
    .dec_i         (s1_q),
    .fixed_codes_i (fixed_codes_q),
    .ll_entry_i    (dthe_pkg::entry_t'(ll_rdata)),
    .dist_entry_i  (dthe_pkg::entry_t'(dist_rdata)),
    .parts_o       (parts)
  );

  // Stage two: length part and distance part.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (rdy2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && s1_valid_q) begin
      s2_q <= parts;
    end
  end

  // Join the distance part above the length part.
  always_comb begin
    out_d.code_bits = 48'(s2_q.ll_bits) | (48'(s2_q.dist_bits) << s2_q.ll_count);
    out_d.bit_count = 6'(s2_q.ll_count) + 6'(s2_q.dist_count);
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy_out) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out && s2_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_code_o  = out_q;

`include "deflate_token_huffman_encoder_core_assert.svh"

  `DTHE_ASSERT(a_count_max, out_valid_o |-> (out_code_o.bit_count <= 6'd48))
  `DTHE_ASSERT(a_bits_masked, out_valid_o |-> ((out_code_o.code_bits >> out_code_o.bit_count) == 48'd0))
  `DTHE_ASSERT(a_load_no_result, (accept && (in_token_i.op == dthe_pkg::OP_LOAD_LL || in_token_i.op == dthe_pkg::OP_LOAD_DIST)) |=> !s1_valid_q)
  `DTHE_ASSERT(a_s2_holds, (s2_valid_q && !rdy_out) |=> (s2_valid_q && $stable(s2_q)))
  `DTHE_ASSERT_NEVER(a_nonmatch_dist, s1_valid_q && !s1_q.is_match && (s1_q.dist_ne != 4'd0))

endmodule
